### hdl/smbs_pkg.sv
// Shared types, constants and helpers for the soil moisture bucket pipeline.
package smbs_pkg;

	// One in Q0.30, the unit of the exponential series.
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	// Half an LSB of Q0.30 for the rounded squarings.
	localparam logic [61:0] Q30_HALF = 62'h2000_0000;
	// One in Q0.16 fractions and ratios.
	localparam logic [16:0] FRAC_ONE = 17'h1_0000;
	localparam int SERIES_TERMS = 12;
	localparam int SQUARINGS = 4;

	// floor(2^32 / i) for the Horner divisors. The entry for one is 2^32 - 1 so
	// that the same single correction step yields the exact quotient.
	localparam logic [31:0] RECIP [1:12] = '{
		32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'h4000_0000,
		32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924, 32'h2000_0000,
		32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174, 32'h1555_5555
	};

	// Item context carried from the input stage down to the clamp stage.
	typedef struct packed {
		logic [15:0] cell_id;
		logic [22:0] s;
		logic [22:0] cap;
		logic        cap_pos;
		logic [16:0] frac;
		logic        surplus;
		logic        r_sat;
		logic [24:0] d;
		logic [24:0] chg_sur;
		logic [22:0] et_base;
		logic [24:0] lim_base;
		logic [16:0] r;
	} ctx_t;

	// Item context after the moisture update.
	typedef struct packed {
		logic [15:0] cell_id;
		logic [22:0] cap;
		logic        cap_pos;
		logic [16:0] frac;
		logic [22:0] s_new;
		logic [24:0] chg;
		logic [22:0] et_base;
		logic [24:0] lim_base;
		logic [25:0] et;
		logic        rsat;
	} post_t;

	// Saturate a signed 28-bit value to signed 24 bits.
	function automatic logic [23:0] sat24(input logic [27:0] v);
		logic [23:0] res;
		if ((v[27:23] == 5'b00000) || (v[27:23] == 5'b11111)) begin
			res = v[23:0];
		end else if (v[27]) begin
			res = 24'h80_0000;
		end else begin
			res = 24'h7F_FFFF;
		end
		return res;
	endfunction

endpackage

### hdl/soil_moisture_bucket_step_top.sv
// Top level of the soil moisture bucket step pipeline.
//
// One grid cell enters per transfer on the slave stream and leaves as one
// result transfer on the master stream, in order. A new cell may be
// transferred in every cycle unless the pipeline holds, so the sustained
// rate is one cell per clock. The pipeline is a chain of arithmetic: a
// 16-step restoring divider for the moisture ratio, two parallel exponential
// units (twelve Horner terms of three stages each, then four squarings of
// two stages each, one unit for the cell and one for the drying shape
// factor), a 20-step divider for the drying curve, the clamp, a second
// 16-step divider for the liquid ratio and the scaling multipliers.
// All stages advance together. The final stage hands its result to an output
// register; the pipeline keeps moving while that register waits, as long as
// the final stage is empty, and holds as a whole otherwise, so nothing is lost
// or repeated. The drying shape factor may only be written between runs.
module soil_moisture_bucket_step_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [11:0]  cfg_wr_data,   // drying_alpha, unsigned Q4.8
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cell_index[15:0], precip[38:16], intercept[61:39], snow_change[85:62],
	// pot_et[108:86], water_capacity[132:109], soil_moist[155:133],
	// irrigated_fraction[172:156], zero fill above
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// cell_index_out[15:0], soil_moist_new[38:16], evapotranspiration[62:39],
	// soil_moist_scaled[85:63], soil_moist_change[109:86],
	// liquid_ratio[126:110], zero fill above
	output logic [127:0] m_axis_tdata
);

	// Stage numbers of the pipeline sections.
	localparam int A_LAST   = 17;  // last step of the ratio divider
	localparam int ST_R     = 18;  // ratio saturation and drying argument
	localparam int ST_DG0   = 63;  // drying curve divider set-up
	localparam int DG_LAST  = 83;
	localparam int ST_MUL   = 84;  // deficit times curve
	localparam int ST_CLAMP = 85;
	localparam int ST_ET    = 86;
	localparam int RD_LAST  = 102;
	localparam int ST_SCALE = 103;

	// Configuration register.
	logic [11:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 12'd1280;
		end else if (cfg_wr_en) begin
			alpha_q <= cfg_wr_data;
		end
	end

	// Flow control. The whole pipeline advances when the final stage is empty or
	// the output register can take its result.
	logic                out_ld;
	logic                adv;
	logic                m_vld_q;
	logic [ST_SCALE:1]   vld_s;

	assign out_ld        = !m_vld_q || m_axis_tready;
	assign adv           = out_ld || !vld_s[ST_SCALE];
	assign s_axis_tready = adv;
	assign m_axis_tvalid = m_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			m_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[ST_SCALE-1:1], s_axis_tvalid};
			end
			if (out_ld) begin
				m_vld_q <= vld_s[ST_SCALE];
			end
		end
	end

	// Input fields.
	logic [15:0] in_cell;
	logic [22:0] in_precip;
	logic [22:0] in_icpt;
	logic [23:0] in_snow;
	logic [22:0] in_pet;
	logic [23:0] in_cap;
	logic [22:0] in_s;
	logic [16:0] in_irr;

	assign in_cell   = s_axis_tdata[15:0];
	assign in_precip = s_axis_tdata[38:16];
	assign in_icpt   = s_axis_tdata[61:39];
	assign in_snow   = s_axis_tdata[85:62];
	assign in_pet    = s_axis_tdata[108:86];
	assign in_cap    = s_axis_tdata[132:109];
	assign in_s      = s_axis_tdata[155:133];
	assign in_irr    = s_axis_tdata[172:156];

	// Stage 1: water balance terms. The water input is precipitation less
	// interception less snow pack change; the demand is the potential rate less
	// interception, never below zero.
	smbs_pkg::ctx_t pre_ctx;
	logic [25:0]    wi;
	logic [22:0]    demand;
	logic [25:0]    diff1;
	logic [25:0]    capms;
	logic [25:0]    dfc;
	logic           cap_pos;
	logic [22:0]    cap23;

	always_comb begin
		cap_pos = !in_cap[23] && (in_cap != 24'd0);
		cap23   = cap_pos ? in_cap[22:0] : 23'd1;
		wi      = {3'b000, in_precip} - {3'b000, in_icpt} - {{2{in_snow[23]}}, in_snow};
		demand  = (in_pet > in_icpt) ? (in_pet - in_icpt) : 23'd0;
		diff1   = wi - {3'b000, demand};
		capms   = {3'b000, cap23} - {3'b000, in_s};
		dfc     = {3'b000, demand} - wi;

		pre_ctx.cell_id  = in_cell;
		pre_ctx.s        = in_s;
		pre_ctx.cap      = cap23;
		pre_ctx.cap_pos  = cap_pos;
		pre_ctx.frac     = (in_irr > smbs_pkg::FRAC_ONE) ? 17'd0 :
			(smbs_pkg::FRAC_ONE - in_irr);
		pre_ctx.surplus  = $signed(wi) > $signed({3'b000, demand});
		pre_ctx.r_sat    = in_s >= cap23;
		pre_ctx.d        = dfc[24:0];
		pre_ctx.chg_sur  = ($signed(diff1) > $signed(capms)) ? capms[24:0] : diff1[24:0];
		pre_ctx.et_base  = (in_pet > in_icpt) ? in_pet : in_icpt;
		pre_ctx.lim_base = {2'b00, in_precip} - {in_snow[23], in_snow};
		pre_ctx.r        = '0;
	end

	smbs_pkg::ctx_t ctx_s [1:ST_MUL];
	logic [22:0]    ra_rem_s [1:A_LAST];
	logic [15:0]    ra_q_s [1:A_LAST];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[1]    <= pre_ctx;
			ra_rem_s[1] <= in_s;
			ra_q_s[1]   <= '0;
		end
	end

	// Stages 2 to 17: moisture over capacity, one quotient bit per stage. When
	// the moisture is at or above capacity the ratio is taken as one instead.
	for (genvar gk = 2; gk <= A_LAST; gk++) begin : g_rdiv
		logic [23:0] tmp;
		logic [23:0] dif;
		logic        ge;

		assign tmp = {ra_rem_s[gk-1], 1'b0};
		assign dif = tmp - {1'b0, ctx_s[gk-1].cap};
		assign ge  = tmp >= {1'b0, ctx_s[gk-1].cap};

		always_ff @(posedge clk) begin
			if (adv) begin
				ra_rem_s[gk] <= ge ? dif[22:0] : tmp[22:0];
				ra_q_s[gk]   <= {ra_q_s[gk-1][14:0], ge};
			end
		end
	end

	// Stage 18: the exponential argument alpha times ratio in Q4.16, and the
	// argument for the normalizing term, alpha itself.
	logic [16:0]    r_c;
	logic [28:0]    ar;
	smbs_pkg::ctx_t ctx_r;
	logic [29:0]    ex_t_s18 [2];

	always_comb begin
		r_c   = ctx_s[A_LAST].r_sat ? smbs_pkg::FRAC_ONE : {1'b0, ra_q_s[A_LAST]};
		ar    = 29'(alpha_q) * 29'(r_c);
		ctx_r = ctx_s[A_LAST];
		ctx_r.r = r_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_t_s18[0] <= {ar[27:8], 10'd0};
			ex_t_s18[1] <= {alpha_q, 18'd0};
		end
	end

	// Context delay line, with the ratio filled in at stage 18.
	for (genvar gk = 2; gk <= ST_MUL; gk++) begin : g_ctx
		if (gk == ST_R) begin : g_put_r
			always_ff @(posedge clk) begin
				if (adv) begin
					ctx_s[gk] <= ctx_r;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					ctx_s[gk] <= ctx_s[gk-1];
				end
			end
		end
	end

	// Stages 19 to 62: exp(-x) for both lanes. Horner series of exp(-x/16),
	// each term a multiply stage, a reciprocal stage and a correction stage,
	// then four rounded squarings.
	logic [29:0] ex_va_s [2][smbs_pkg::SERIES_TERMS];
	logic [29:0] ex_ta_s [2][smbs_pkg::SERIES_TERMS];
	logic [29:0] ex_vb_s [2][smbs_pkg::SERIES_TERMS];
	logic [29:0] ex_q0_s [2][smbs_pkg::SERIES_TERMS];
	logic [29:0] ex_tb_s [2][smbs_pkg::SERIES_TERMS];
	logic [30:0] ex_pc_s [2][smbs_pkg::SERIES_TERMS];
	logic [29:0] ex_tc_s [2][smbs_pkg::SERIES_TERMS];
	logic [61:0] ex_sq_s [2][smbs_pkg::SQUARINGS];
	logic [30:0] ex_pr_s [2][smbs_pkg::SQUARINGS];

	for (genvar gl = 0; gl < 2; gl++) begin : g_lane
		for (genvar gj = 0; gj < smbs_pkg::SERIES_TERMS; gj++) begin : g_term
			localparam int DIV = smbs_pkg::SERIES_TERMS - gj;
			logic [29:0] t_in;
			logic [30:0] p_in;
			logic [60:0] tp;
			logic [61:0] qm;
			logic [33:0] qi;
			logic [29:0] rr;
			logic [29:0] qc;

			if (gj == 0) begin : g_first
				assign t_in = ex_t_s18[gl];
				assign p_in = smbs_pkg::Q30_ONE;
			end else begin : g_next
				assign t_in = ex_tc_s[gl][gj-1];
				assign p_in = ex_pc_s[gl][gj-1];
			end

			assign tp = 61'(t_in) * 61'(p_in);
			assign qm = 62'(ex_va_s[gl][gj]) * 62'(smbs_pkg::RECIP[DIV]);
			assign qi = 34'(ex_q0_s[gl][gj]) * 34'(DIV);
			assign rr = ex_vb_s[gl][gj] - qi[29:0];
			assign qc = (rr >= 30'(DIV)) ? (ex_q0_s[gl][gj] + 30'd1) : ex_q0_s[gl][gj];

			always_ff @(posedge clk) begin
				if (adv) begin
					ex_va_s[gl][gj] <= tp[59:30];
					ex_ta_s[gl][gj] <= t_in;
					ex_vb_s[gl][gj] <= ex_va_s[gl][gj];
					ex_q0_s[gl][gj] <= qm[61:32];
					ex_tb_s[gl][gj] <= ex_ta_s[gl][gj];
					ex_pc_s[gl][gj] <= smbs_pkg::Q30_ONE - {1'b0, qc};
					ex_tc_s[gl][gj] <= ex_tb_s[gl][gj];
				end
			end
		end

		for (genvar gq = 0; gq < smbs_pkg::SQUARINGS; gq++) begin : g_sq
			logic [30:0] p_in;
			logic [61:0] sr;

			if (gq == 0) begin : g_first
				assign p_in = ex_pc_s[gl][smbs_pkg::SERIES_TERMS-1];
			end else begin : g_next
				assign p_in = ex_pr_s[gl][gq-1];
			end

			assign sr = ex_sq_s[gl][gq] + smbs_pkg::Q30_HALF;

			always_ff @(posedge clk) begin
				if (adv) begin
					ex_sq_s[gl][gq] <= 62'(p_in) * 62'(p_in);
					ex_pr_s[gl][gq] <= sr[60:30];
				end
			end
		end
	end

	// Stage 63: drying curve numerator and denominator, 1 - exp(-x) and
	// 1 - exp(-alpha). Stages 64 to 83 divide the numerator times 2^16.
	logic [30:0] num_c;
	logic [30:0] dg_rem_s [ST_DG0:DG_LAST];
	logic [19:0] dg_q_s [ST_DG0:DG_LAST];
	logic [3:0]  dg_lo_s [ST_DG0:DG_LAST];
	logic [30:0] dg_den_s [ST_DG0:DG_LAST];

	assign num_c = smbs_pkg::Q30_ONE - ex_pr_s[0][smbs_pkg::SQUARINGS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dg_rem_s[ST_DG0] <= {4'd0, num_c[30:4]};
			dg_q_s[ST_DG0]   <= '0;
			dg_lo_s[ST_DG0]  <= num_c[3:0];
			dg_den_s[ST_DG0] <= smbs_pkg::Q30_ONE - ex_pr_s[1][smbs_pkg::SQUARINGS-1];
		end
	end

	for (genvar gk = ST_DG0 + 1; gk <= DG_LAST; gk++) begin : g_gdiv
		localparam int STEP = gk - ST_DG0 - 1;
		logic        bin;
		logic [31:0] tmp;
		logic [31:0] dif;
		logic        ge;

		if (STEP < 4) begin : g_num_bit
			assign bin = dg_lo_s[gk-1][3-STEP];
		end else begin : g_zero_bit
			assign bin = 1'b0;
		end

		assign tmp = {dg_rem_s[gk-1], bin};
		assign dif = tmp - {1'b0, dg_den_s[gk-1]};
		assign ge  = tmp >= {1'b0, dg_den_s[gk-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dg_rem_s[gk] <= ge ? dif[30:0] : tmp[30:0];
				dg_q_s[gk]   <= {dg_q_s[gk-1][18:0], ge};
				dg_lo_s[gk]  <= dg_lo_s[gk-1];
				dg_den_s[gk] <= dg_den_s[gk-1];
			end
		end
	end

	// Stage 84: the deficit times the drying curve, rounded half up. A zero
	// denominator means alpha is too small to shape the curve, and the curve
	// falls back to the plain ratio.
	logic [19:0] gm;
	logic [45:0] dm;
	logic [29:0] mag_s84;

	assign gm = (dg_den_s[DG_LAST] == 31'd0) ? 20'(ctx_s[DG_LAST].r) : dg_q_s[DG_LAST];
	assign dm = 46'(ctx_s[DG_LAST].d) * 46'(gm) + 46'd32768;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s84 <= dm[45:16];
		end
	end

	// Stage 85: pick the surplus or deficit change and clamp it so that the
	// moisture stays between zero and capacity. No soil means no change.
	smbs_pkg::ctx_t cc;
	smbs_pkg::post_t post_c;
	logic [31:0]    chg_raw;
	logic [31:0]    s32;
	logic [31:0]    cap32;
	logic [31:0]    sum32;
	logic [31:0]    chg2;
	logic [31:0]    snew32;

	always_comb begin
		cc      = ctx_s[ST_MUL];
		s32     = {9'd0, cc.s};
		cap32   = {9'd0, cc.cap};
		chg_raw = cc.surplus ? {{7{cc.chg_sur[24]}}, cc.chg_sur} : (32'd0 - {2'b00, mag_s84});
		sum32   = s32 + chg_raw;
		if ($signed(sum32) > $signed(cap32)) begin
			chg2 = cap32 - s32;
		end else if ($signed(sum32) < 0) begin
			chg2 = 32'd0 - s32;
		end else begin
			chg2 = chg_raw;
		end
		snew32 = s32 + chg2;

		post_c.cell_id  = cc.cell_id;
		post_c.cap      = cc.cap;
		post_c.cap_pos  = cc.cap_pos;
		post_c.frac     = cc.frac;
		post_c.s_new    = cc.cap_pos ? snew32[22:0] : 23'd0;
		post_c.chg      = cc.cap_pos ? chg2[24:0] : 25'd0;
		post_c.et_base  = cc.et_base;
		post_c.lim_base = cc.lim_base;
		post_c.et       = '0;
		post_c.rsat     = 1'b0;
	end

	// Stage 86: actual evapotranspiration, the lesser of demand plus
	// interception and the water that is left after the soil change.
	smbs_pkg::post_t post_s [ST_CLAMP:RD_LAST];
	smbs_pkg::post_t post_e;
	logic [25:0]     lim_m;
	logic [25:0]     etb;

	always_comb begin
		post_e = post_s[ST_CLAMP];
		lim_m  = {post_e.lim_base[24], post_e.lim_base} - {post_e.chg[24], post_e.chg};
		etb    = {3'b000, post_e.et_base};
		post_e.et   = ($signed(lim_m) < $signed(etb)) ? lim_m : etb;
		post_e.rsat = post_e.s_new == post_e.cap;
	end

	logic [22:0] rd_rem_s [ST_ET:RD_LAST];
	logic [15:0] rd_q_s [ST_ET:RD_LAST];

	always_ff @(posedge clk) begin
		if (adv) begin
			post_s[ST_CLAMP] <= post_c;
			post_s[ST_ET]    <= post_e;
			rd_rem_s[ST_ET]  <= post_s[ST_CLAMP].s_new;
			rd_q_s[ST_ET]    <= '0;
		end
	end

	// Stages 87 to 102: new moisture over capacity, one bit per stage.
	for (genvar gk = ST_ET + 1; gk <= RD_LAST; gk++) begin : g_ldiv
		logic [23:0] tmp;
		logic [23:0] dif;
		logic        ge;

		assign tmp = {rd_rem_s[gk-1], 1'b0};
		assign dif = tmp - {1'b0, post_s[gk-1].cap};
		assign ge  = tmp >= {1'b0, post_s[gk-1].cap};

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_rem_s[gk] <= ge ? dif[22:0] : tmp[22:0];
				rd_q_s[gk]   <= {rd_q_s[gk-1][14:0], ge};
				post_s[gk]   <= post_s[gk-1];
			end
		end
	end

	// Stage 103: scale by the non-irrigated fraction with a half LSB added,
	// so that the later shift rounds to nearest with ties upward.
	smbs_pkg::post_t pl;
	logic [43:0]     pe_c;
	logic [43:0]     pc_c;
	logic [39:0]     ps_c;
	logic [43:0]     sc_et_s103;
	logic [43:0]     sc_ch_s103;
	logic [39:0]     sc_sm_s103;
	logic [16:0]     ratio_s103;
	logic [15:0]     cell_s103;
	logic [22:0]     snew_s103;

	always_comb begin
		pl   = post_s[RD_LAST];
		pe_c = {{18{pl.et[25]}}, pl.et} * {27'd0, pl.frac} + 44'd32768;
		pc_c = {{19{pl.chg[24]}}, pl.chg} * {27'd0, pl.frac} + 44'd32768;
		ps_c = {17'd0, pl.s_new} * {23'd0, pl.frac} + 40'd32768;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_et_s103 <= pe_c;
			sc_ch_s103 <= pc_c;
			sc_sm_s103 <= ps_c;
			ratio_s103 <= !pl.cap_pos ? 17'd0 :
				(pl.rsat ? smbs_pkg::FRAC_ONE : {1'b0, rd_q_s[RD_LAST]});
			cell_s103  <= pl.cell_id;
			snew_s103  <= pl.s_new;
		end
	end

	// Output register: arithmetic shift and saturation of the signed results.
	logic [15:0] cell_q;
	logic [22:0] snew_q;
	logic [23:0] et_q;
	logic [22:0] sm_q;
	logic [23:0] chg_q;
	logic [16:0] ratio_q;

	always_ff @(posedge clk) begin
		if (out_ld) begin
			cell_q  <= cell_s103;
			snew_q  <= snew_s103;
			et_q    <= smbs_pkg::sat24(sc_et_s103[43:16]);
			sm_q    <= sc_sm_s103[38:16];
			chg_q   <= smbs_pkg::sat24(sc_ch_s103[43:16]);
			ratio_q <= ratio_s103;
		end
	end

	assign m_axis_tdata = {1'b0, ratio_q, chg_q, sm_q, et_q, snew_q, cell_q};

	// A full ratio can only come from moisture equal to a positive capacity.
	a_full_ratio_has_moisture: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q && (ratio_q == smbs_pkg::FRAC_ONE) |-> (snew_q != 23'd0))
		else $error("full liquid ratio with zero moisture");

	// The liquid ratio never passes one.
	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q |-> (ratio_q <= smbs_pkg::FRAC_ONE))
		else $error("liquid ratio above one");

	// Scaling by a fraction of at most one never grows the moisture.
	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q |-> (sm_q <= snew_q))
		else $error("scaled moisture above unscaled moisture");

	// A stalled final stage keeps its item.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_SCALE] && !adv |=> vld_s[ST_SCALE])
		else $error("item dropped from final stage during stall");

endmodule

### sim/soil_moisture_bucket_step_top_test.sv
// Self-checking testbench for the soil moisture bucket step pipeline.
module soil_moisture_bucket_step_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One cell as it travels on the input stream.
	typedef struct packed {
		logic [16:0] irr;
		logic [22:0] moist;
		logic [23:0] cap;
		logic [22:0] pet;
		logic [23:0] snow;
		logic [22:0] icpt;
		logic [22:0] precip;
		logic [15:0] cell_id;
	} cell_in_t;

	// One result as it travels on the output stream.
	typedef struct packed {
		logic [16:0] ratio;
		logic [23:0] chg;
		logic [22:0] moist_scaled;
		logic [23:0] et;
		logic [22:0] moist_new;
		logic [15:0] cell_id;
	} cell_out_t;

	localparam int LATENCY = 104;
	localparam longint Q30 = 64'd1 << 30;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [11:0] cfg_wr_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [127:0] m_axis_tdata;

	// Copy of the drying shape factor used by the predictor.
	logic [11:0] alpha_model;

	cell_in_t  pending_cells[$];
	cell_out_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int cells_sent;
	int burst_left;
	int gap_left;
	int holdoff_left;
	bit holdoff_request;

	soil_moisture_bucket_step_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exp(-x) in Q0.30 for x in Q4.16: Horner series on x/16, then four squarings.
	function automatic longint unsigned exp_neg_q30(input longint unsigned x);
		longint unsigned t;
		longint unsigned p;
		t = (x & 64'hFFFFF) << 10;
		p = Q30;
		for (int i = 12; i >= 1; i--) begin
			p = Q30 - (((t * p) >> 30) / i);
		end
		for (int k = 0; k < 4; k++) begin
			p = (p * p + (Q30 >> 1)) >> 30;
		end
		return p;
	endfunction

	// Multiply by a Q0.16 fraction, rounding to nearest with ties upward.
	function automatic longint scale_by_frac(input longint v, input longint f);
		longint p;
		p = v * f + 32768;
		if (p >= 0) begin
			return p / 65536;
		end
		return -((-p + 65535) / 65536);
	endfunction

	function automatic logic [23:0] clip24(input longint v);
		if (v > 8388607) begin
			return 24'h7F_FFFF;
		end
		if (v < -8388608) begin
			return 24'h80_0000;
		end
		return v[23:0];
	endfunction

	// Predicts the water balance of one cell.
	function automatic cell_out_t bucket_update(input cell_in_t c);
		cell_out_t o;
		longint precip, icpt, snow, pet, cap, s, irr, frac;
		longint water_in, demand, chg, s_new, et, lim;
		longint unsigned r, x, num, den, gm, d, ratio_new;
		precip = c.precip;
		icpt = c.icpt;
		snow = $signed(c.snow);
		pet = c.pet;
		cap = $signed(c.cap);
		s = c.moist;
		irr = c.irr;
		chg = 0;
		s_new = 0;
		ratio_new = 0;
		if (irr > 65536) begin
			irr = 65536;
		end
		frac = 65536 - irr;
		water_in = precip - icpt - snow;
		demand = (pet > icpt) ? pet - icpt : 0;
		if (cap > 0) begin
			if (water_in > demand) begin
				chg = water_in - demand;
				if (chg > cap - s) begin
					chg = cap - s;
				end
			end else begin
				// Drying: the deficit is scaled by the exponential curve.
				r = (longint'(s) << 16) / cap;
				d = demand - water_in;
				if (r > 65536) begin
					r = 65536;
				end
				x = (longint'(alpha_model) * r) >> 8;
				num = Q30 - exp_neg_q30(x);
				den = Q30 - exp_neg_q30(longint'(alpha_model) << 8);
				gm = (den != 0) ? (num << 16) / den : r;
				chg = -longint'((d * gm + 32768) >> 16);
			end
			if (s + chg > cap) begin
				chg = cap - s;
			end
			if (s + chg < 0) begin
				chg = -s;
			end
			s_new = s + chg;
			ratio_new = (longint'(s_new) << 16) / cap;
			if (ratio_new > 65536) begin
				ratio_new = 65536;
			end
		end
		et = demand + icpt;
		lim = precip - snow - chg;
		if (lim < et) begin
			et = lim;
		end
		o.cell_id = c.cell_id;
		o.moist_new = s_new[22:0];
		o.et = clip24(scale_by_frac(et, frac));
		o.moist_scaled = 23'(scale_by_frac(s_new, frac));
		o.chg = clip24(scale_by_frac(chg, frac));
		o.ratio = ratio_new[16:0];
		return o;
	endfunction

	// Driver: bursts of valid cycles separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
			cells_sent <= 0;
		end else begin
			automatic bit taken = s_axis_tvalid && s_axis_tready;
			automatic bit busy = s_axis_tvalid && !s_axis_tready;
			if (taken) begin
				expected_results.push_back(bucket_update(cell_in_t'(s_axis_tdata[172:0])));
				cells_sent <= cells_sent + 1;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_cells.size() > 0) begin
					s_axis_tdata <= {3'b0, pending_cells.pop_front()};
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall pattern, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			holdoff_left <= 0;
		end else begin
			if (holdoff_request && holdoff_left == 0) begin
				holdoff_left <= 400;
				m_axis_tready <= 1'b0;
			end else if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
				m_axis_tready <= (holdoff_left == 1);
			end else begin
				m_axis_tready <= ((cells_sent / 200) % 2 == 0) ? 1'b1
					: ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			automatic cell_out_t got = cell_out_t'(m_axis_tdata[126:0]);
			automatic cell_out_t want;
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%t: result with no cell outstanding: %h", $realtime, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.cell_id !== want.cell_id) begin
					$display("%t: cell_index_out expected %h got %h", $realtime,
						want.cell_id, got.cell_id);
					errors++;
				end
				if (got.moist_new !== want.moist_new) begin
					$display("%t: soil_moist_new expected %h got %h", $realtime,
						want.moist_new, got.moist_new);
					errors++;
				end
				if (got.et !== want.et) begin
					$display("%t: evapotranspiration expected %h got %h", $realtime, want.et, got.et);
					errors++;
				end
				if (got.moist_scaled !== want.moist_scaled) begin
					$display("%t: soil_moist_scaled expected %h got %h", $realtime,
						want.moist_scaled, got.moist_scaled);
					errors++;
				end
				if (got.chg !== want.chg) begin
					$display("%t: soil_moist_change expected %h got %h", $realtime, want.chg, got.chg);
					errors++;
				end
				if (got.ratio !== want.ratio) begin
					$display("%t: liquid_ratio expected %h got %h", $realtime, want.ratio, got.ratio);
					errors++;
				end
			end
		end
	end

	// Random cell; most have realistic depths so the drying curve is exercised.
	function automatic cell_in_t random_cell();
		cell_in_t c;
		c.cell_id = 16'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			c.precip = 23'($urandom);
			c.icpt = 23'($urandom);
			c.snow = 24'($urandom);
			c.pet = 23'($urandom);
			c.cap = 24'($urandom);
			c.moist = 23'($urandom);
			c.irr = 17'($urandom);
		end else begin
			c.precip = 23'($urandom_range(0, 20000));
			c.icpt = ($urandom_range(0, 2) == 0) ? 23'd0 : 23'($urandom_range(0, 2000));
			c.snow = 24'($signed($urandom_range(0, 6000)) - 3000);
			c.pet = 23'($urandom_range(0, 20000));
			c.cap = ($urandom_range(0, 9) == 0) ? 24'(-$signed($urandom_range(0, 100)))
				: 24'($urandom_range(1, 60000));
			c.moist = 23'($urandom_range(0, 70000));
			c.irr = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(65536, 131071))
				: 17'($urandom_range(0, 65536));
		end
		return c;
	endfunction

	function automatic cell_in_t make_cell(input logic [15:0] id, input logic [22:0] p,
			input logic [22:0] ic, input logic [23:0] sn, input logic [22:0] pe,
			input logic [23:0] ca, input logic [22:0] mo, input logic [16:0] ir);
		cell_in_t c;
		c = '{irr: ir, moist: mo, cap: ca, pet: pe, snow: sn, icpt: ic, precip: p, cell_id: id};
		return c;
	endfunction

	// Waits until every expected result has arrived and the pipeline drained.
	task automatic drain();
		while (pending_cells.size() > 0 || s_axis_tvalid || expected_results.size() > 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [11:0] a);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alpha_model = a;
	endtask

	initial begin
		automatic logic [11:0] alpha_set[5] = '{12'd1280, 12'd1, 12'd4095, 12'd0, 12'd300};
		holdoff_request = 1'b0;
		alpha_model = 12'd1280;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cells: field extremes, no soil, oversaturation, full irrigation.
		pending_cells.push_back(make_cell(16'h0000, 0, 0, 0, 0, 0, 0, 0));
		pending_cells.push_back(make_cell(16'hFFFF, 23'h7FFFFF, 0, 24'h800000, 0, 24'h7FFFFF,
			23'h7FFFFF, 0));
		pending_cells.push_back(make_cell(16'h1234, 0, 23'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
			24'h800000, 23'h7FFFFF, 17'h1FFFF));
		pending_cells.push_back(make_cell(1, 1000, 100, 0, 500, 24'hFFFFFF, 200, 0));
		pending_cells.push_back(make_cell(2, 100, 0, 0, 5000, 1000, 3000, 0));
		pending_cells.push_back(make_cell(3, 5000, 0, 0, 100, 1000, 900, 32768));
		pending_cells.push_back(make_cell(4, 0, 0, 0, 20000, 1000, 500, 65536));
		pending_cells.push_back(make_cell(5, 0, 0, 0, 23'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 0));
		pending_cells.push_back(make_cell(6, 23'h7FFFFF, 0, 24'h800000, 0, 1, 0, 1));
		pending_cells.push_back(make_cell(7, 300, 400, 24'hFFFF00, 200, 5000, 0, 65535));
		pending_cells.push_back(make_cell(8, 0, 0, 24'h000100, 1000, 4000, 4000, 100000));
		pending_cells.push_back(make_cell(9, 23'h555555, 23'h2AAAAA, 24'hAAAAAA, 23'h2AAAAA,
			24'h555555, 23'h555555, 17'h0AAAA));
		drain();

		// Random cells across several drying shapes, with one long output hold-off.
		foreach (alpha_set[k]) begin
			write_alpha(alpha_set[k]);
			repeat (290) pending_cells.push_back(random_cell());
			if (k == 1) begin
				holdoff_request <= 1'b1;
				@(posedge clk);
				holdoff_request <= 1'b0;
			end
			drain();
		end

		$display("Covered %0d cells and %0d results over five drying shapes,", cells_sent,
			results_seen);
		$display("including no-soil, oversaturated and fully irrigated cells and a long stall.");
		if (errors == 0) begin
			$display("soil_moisture_bucket_step_top regression: pass");
		end else begin
			$display("soil_moisture_bucket_step_top regression: fail");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("soil_moisture_bucket_step_top regression: fail");
		$finish;
	end

endmodule
